### rtl/core/tab_expander_stop_list_defines.svh
// Assertion helpers shared by the checker files.
`ifndef TAB_EXPANDER_STOP_LIST_DEFINES_SVH
`define TAB_EXPANDER_STOP_LIST_DEFINES_SVH

// Same-cycle implication.
`define TES_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tab expander check failed");

// Next-cycle implication.
`define TES_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tab expander check failed");

`endif

### rtl/core/tes_pkg.sv
package tes_pkg;

   localparam int CHAR_W = 8;
   localparam int COL_W  = 12;
   localparam int ALU_W  = COL_W + 1;
   localparam int IV_W   = 7;
   localparam int CNT_SC_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int STEP_W = $clog2(COL_W);

   localparam int MAX_STOPS_DEFAULT  = 6;
   localparam int MAX_SPACES_DEFAULT = 64;

   localparam logic [COL_W-1:0]  COL_MAX  = 12'd4095;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   localparam logic [IV_W-1:0] TAB_INTERVAL_RESET = 7'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_A       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_F       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_INTERVAL = 3'd7;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] value;
      logic             neg;
      logic             zero;
   } alu_rsp_type;

endpackage

### rtl/core/tes_alu.sv
module tes_alu (
   input  tes_pkg::alu_req_type req,
   output tes_pkg::alu_rsp_type rsp
);

   logic [tes_pkg::ALU_W-1:0] result;

   // Operands are zero-extended columns, so the top bit flags a borrow or a carry out.
   assign result = (req.op == tes_pkg::ALU_SUB) ? req.a - req.b : req.a + req.b;

   assign rsp.value = result;
   assign rsp.neg   = result[tes_pkg::ALU_W-1];
   assign rsp.zero  = (result == '0);

endmodule

### rtl/core/tes_emitter.sv
module tes_emitter #(
   parameter int MAX_SPACES = tes_pkg::MAX_SPACES_DEFAULT,
   localparam int CNT_W = $clog2(MAX_SPACES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [tes_pkg::CHAR_W-1:0] load_char,
   input  logic [CNT_W-1:0]           load_count,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tes_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last
);

   logic [CNT_W-1:0]           count_ff, count_in;
   logic [tes_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                       valid_ff, valid_in;
   logic [tes_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic                       last_ff, last_in;
   logic                       push;

   assign free = (count_ff == '0);
   // Move the next copy into the output register once it is empty or being taken.
   assign push = !free && (!valid_ff || rsp_ready);

   always_comb begin
      count_in    = count_ff;
      char_in     = char_ff;
      valid_in    = valid_ff;
      out_char_in = out_char_ff;
      last_in     = last_ff;
      if (load) begin
         count_in = load_count;
         char_in  = load_char;
      end else if (push) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (push) begin
         valid_in    = 1'b1;
         out_char_in = char_ff;
         last_in     = (count_ff == CNT_W'(1));
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      char_ff     <= char_in;
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = last_ff;

endmodule

### rtl/core/tab_expander_stop_list.sv
// Ordinary character or newline: loaded into the emitter, then moved to its output register, and
// the next item is taken once it has moved. Tab: passed stops are skipped in turn; the spaces go
// to the next stop, the last stop, or via the 12-step remainder on the default interval; then one
// space per cycle unless the output stalls, up to MAX_SPACES; the next item waits for the last.
// One shared 13-bit add/subtract unit does the stop compares, divide steps and column update.
// Reset (synchronous, active high) clears column, stop index and registers to their defaults.
module tab_expander_stop_list #(
   parameter int MAX_STOPS  = tes_pkg::MAX_STOPS_DEFAULT,
   parameter int MAX_SPACES = tes_pkg::MAX_SPACES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tes_pkg::CHAR_W-1:0]     req_char_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tes_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [tes_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tes_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_SPACES + 1);
   localparam int SIDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int COL_W  = tes_pkg::COL_W;
   localparam int ALU_W  = tes_pkg::ALU_W;
   localparam int IV_W   = tes_pkg::IV_W;
   localparam int SC_W   = tes_pkg::CNT_SC_W;
   localparam int STEP_W = tes_pkg::STEP_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_BASE   = 3'd2;
   localparam logic [2:0] S_DPREP  = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;
   localparam logic [2:0] S_COLUPD = 3'd6;

   logic [SC_W-1:0]   stop_count_ff;
   logic [COL_W-1:0]  stop_ff [MAX_STOPS];
   logic [IV_W-1:0]   tab_interval_ff;
   logic [SC_W-1:0]   csr_slot;

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [SC_W-1:0]   idx_ff, idx_in;
   logic [ALU_W-1:0]  raw_ff, raw_in;
   logic [COL_W-1:0]  dvd_ff, dvd_in;
   logic [IV_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [SC_W-1:0]   n_used;
   logic [IV_W-1:0]   iv;
   logic [SC_W-1:0]   rd_slot;
   logic [COL_W-1:0]  stop_sel;
   logic [COL_W-1:0]  base;
   logic [IV_W:0]     shifted;
   logic [CNT_W-1:0]  spaces;
   logic              accept;

   tes_pkg::alu_req_type alu_req;
   tes_pkg::alu_rsp_type alu_rsp;

   logic                       em_load;
   logic [tes_pkg::CHAR_W-1:0] em_char;
   logic [CNT_W-1:0]           em_count;
   logic                       em_free;

   // Configuration registers.
   assign csr_slot = csr_index - tes_pkg::CSR_STOP_A;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff   <= '0;
         tab_interval_ff <= tes_pkg::TAB_INTERVAL_RESET;
         for (int i = 0; i < MAX_STOPS; i++) begin
            stop_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index) inside
            tes_pkg::CSR_STOP_COUNT: begin
               stop_count_ff <= csr_wdata[SC_W-1:0];
            end
            [tes_pkg::CSR_STOP_A:tes_pkg::CSR_STOP_F]: begin
               // Slots beyond the stop storage are never read: drop them.
               for (int i = 0; i < MAX_STOPS; i++) begin
                  if (csr_slot == SC_W'(i)) begin
                     stop_ff[i] <= csr_wdata[COL_W-1:0];
                  end
               end
            end
            tes_pkg::CSR_TAB_INTERVAL: begin
               tab_interval_ff <= csr_wdata[IV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign n_used = (stop_count_ff > SC_W'(MAX_STOPS)) ? SC_W'(MAX_STOPS) : stop_count_ff;
   assign iv     = (tab_interval_ff == '0) ? IV_W'(1) : tab_interval_ff;

   // Single read port: the last stop while working from the base, else the next stop.
   assign rd_slot  = (state_ff == S_BASE || state_ff == S_DPREP) ? n_used - SC_W'(1) : idx_ff;
   assign stop_sel = (rd_slot < SC_W'(MAX_STOPS)) ? stop_ff[rd_slot[SIDX_W-1:0]] : '0;
   assign base     = (n_used == '0) ? '0 : stop_sel;

   assign shifted = {rem_ff, dvd_ff[COL_W-1]};
   assign spaces  = (raw_ff > ALU_W'(MAX_SPACES)) ? CNT_W'(MAX_SPACES) : raw_ff[CNT_W-1:0];

   assign req_ready = (state_ff == S_IDLE) && em_free;
   assign accept    = req_valid && req_ready;

   tes_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   always_comb begin
      state_in  = state_ff;
      column_in = column_ff;
      idx_in    = idx_ff;
      raw_in    = raw_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      alu_req   = '{op: tes_pkg::ALU_SUB, a: '0, b: '0};
      em_load   = 1'b0;
      em_char   = req_char_in;
      em_count  = CNT_W'(1);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_char_in == tes_pkg::CH_NL) begin
                  column_in = '0;
                  idx_in    = '0;
                  em_load   = 1'b1;
               end else if (req_char_in == tes_pkg::CH_TAB) begin
                  state_in = S_SCAN;
               end else begin
                  if (column_ff < tes_pkg::COL_MAX) begin
                     column_in = column_ff + COL_W'(1);
                  end
                  em_load = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff < n_used) begin
               alu_req.a = {1'b0, stop_sel};
               alu_req.b = {1'b0, column_ff};
               if (alu_rsp.neg || alu_rsp.zero) begin
                  // Passed stop: skip it for the rest of the line.
                  idx_in = idx_ff + SC_W'(1);
               end else begin
                  raw_in   = alu_rsp.value;
                  state_in = S_COLUPD;
               end
            end else begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            alu_req.a = {1'b0, base};
            alu_req.b = {1'b0, column_ff};
            if (!alu_rsp.neg && !alu_rsp.zero) begin
               raw_in   = alu_rsp.value;
               state_in = S_COLUPD;
            end else begin
               state_in = S_DPREP;
            end
         end
         S_DPREP: begin
            alu_req.a = {1'b0, column_ff};
            alu_req.b = {1'b0, base};
            dvd_in    = alu_rsp.value[COL_W-1:0];
            rem_in    = '0;
            step_in   = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            // Restoring divide step: keep only the remainder.
            alu_req.a = ALU_W'(shifted);
            alu_req.b = ALU_W'(iv);
            rem_in    = alu_rsp.neg ? shifted[IV_W-1:0] : alu_rsp.value[IV_W-1:0];
            dvd_in    = {dvd_ff[COL_W-2:0], 1'b0};
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(COL_W - 1)) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            alu_req.a = ALU_W'(iv);
            alu_req.b = ALU_W'(rem_ff);
            raw_in    = alu_rsp.value;
            state_in  = S_COLUPD;
         end
         S_COLUPD: begin
            alu_req.op = tes_pkg::ALU_ADD;
            alu_req.a  = {1'b0, column_ff};
            alu_req.b  = ALU_W'(spaces);
            column_in  = alu_rsp.neg ? tes_pkg::COL_MAX : alu_rsp.value[COL_W-1:0];
            em_load    = 1'b1;
            em_char    = tes_pkg::CH_SPACE;
            em_count   = spaces;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         column_ff <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         column_ff <= column_in;
         idx_ff    <= idx_in;
      end
      raw_ff  <= raw_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   tes_emitter #(
      .MAX_SPACES (MAX_SPACES)
   ) u_emitter (
      .clock        (clock),
      .reset        (reset),
      .load         (em_load),
      .load_char    (em_char),
      .load_count   (em_count),
      .free         (em_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

### rtl/core/tes_checker.sv
`include "tab_expander_stop_list_defines.svh"

module tes_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [tes_pkg::CHAR_W-1:0] rsp_out_char,
   input logic                       rsp_last
);

   // A stalled result holds.
   `TES_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))

   // An accepted item blocks the input for at least the next cycle.
   `TES_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // Only a tab gives more than one result, and those are spaces.
   `TES_ASSERT_IMP(a_multi_is_space, clock, reset, rsp_valid && !rsp_last, rsp_out_char == tes_pkg::CH_SPACE)

   // No new item while a tab still has spaces to deliver.
   `TES_ASSERT_IMP(a_no_accept_mid_tab, clock, reset, rsp_valid && !rsp_last, !req_ready)

endmodule

bind tab_expander_stop_list tes_checker u_checker (.*);

### test/tab_expander_stop_list_tb.sv
`timescale 1ns / 100ps

module tab_expander_stop_list_tb;

   localparam int unsigned STOP_SLOTS  = tes_pkg::MAX_STOPS_DEFAULT;
   localparam int unsigned SPACE_LIMIT = tes_pkg::MAX_SPACES_DEFAULT;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned PRINT_CAP   = 40;

   typedef struct {
      logic [tes_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } out_char_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [tes_pkg::CHAR_W-1:0]     req_char_in = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [tes_pkg::CHAR_W-1:0]     rsp_out_char;
   logic                           rsp_last;
   logic                           csr_we = 1'b0;
   logic [tes_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tes_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // pending input bytes and predicted output bytes
   logic [tes_pkg::CHAR_W-1:0] pending_chars[$];
   out_char_type               expected_chars[$];

   // shadow of the register file
   logic [tes_pkg::CNT_SC_W-1:0] stop_count_cfg;
   logic [tes_pkg::COL_W-1:0]    stop_col_cfg[STOP_SLOTS];
   logic [tes_pkg::IV_W-1:0]     interval_cfg;

   // line state as the block should track it
   logic [tes_pkg::COL_W-1:0]    column;
   logic [tes_pkg::CNT_SC_W-1:0] stop_idx;

   // settings staged for the next register update
   logic [tes_pkg::CNT_SC_W-1:0] setup_count;
   logic [tes_pkg::COL_W-1:0]    setup_stops[STOP_SLOTS];
   logic [tes_pkg::IV_W-1:0]     setup_interval;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned hold_left = 0;
   bit          hold_arm = 1'b0;
   bit          hold_arm_q = 1'b0;

   tab_expander_stop_list i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // Work out the bytes one input byte turns into and advance the line state.
   function automatic void expand_char(input logic [tes_pkg::CHAR_W-1:0] ch);
      int unsigned  n_stops, step, base, target, spaces;
      out_char_type o;
      if (ch == tes_pkg::CH_NL) begin
         column   = '0;
         stop_idx = '0;
         o.ch     = ch;
         o.last   = 1'b1;
         expected_chars.push_back(o);
      end else if (ch != tes_pkg::CH_TAB) begin
         if (column < tes_pkg::COL_MAX) column = column + 1'b1;
         o.ch   = ch;
         o.last = 1'b1;
         expected_chars.push_back(o);
      end else begin
         n_stops = (stop_count_cfg > STOP_SLOTS) ? STOP_SLOTS : stop_count_cfg;
         step    = (interval_cfg == 0) ? 1 : interval_cfg;
         // skip stops already passed on this line
         while (stop_idx < n_stops && stop_col_cfg[stop_idx] <= column) stop_idx++;
         if (stop_idx < n_stops) begin
            target = stop_col_cfg[stop_idx];
         end else begin
            base = (n_stops > 0) ? stop_col_cfg[n_stops - 1] : 0;
            if (base > column) target = base;
            else target = base + ((column - base) / step + 1) * step;
         end
         spaces = target - column;
         if (spaces > SPACE_LIMIT) spaces = SPACE_LIMIT;
         if (spaces < 1) spaces = 1;
         column = (column + spaces > tes_pkg::COL_MAX) ? tes_pkg::COL_MAX
                                                       : tes_pkg::COL_W'(column + spaces);
         for (int k = 0; k < spaces; k++) begin
            o.ch   = tes_pkg::CH_SPACE;
            o.last = (k + 1 == spaces);
            expected_chars.push_back(o);
         end
      end
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_char_in <= '0;
      end else begin
         if (req_valid && req_ready) expand_char(req_char_in);
         if (!req_valid || req_ready) begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_char_in <= pending_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started on a rising hold_arm
   always @(posedge clock) begin
      hold_arm_q <= hold_arm;
      if (hold_arm && !hold_arm_q) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // output monitor
   always @(posedge clock) begin
      out_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_error($sformatf("unexpected output char 0x%02h last %0b",
                                      rsp_out_char, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch)
                  report_error($sformatf("out_char 0x%02h, expected 0x%02h",
                                         rsp_out_char, want.ch));
               if (rsp_last !== want.last)
                  report_error($sformatf("last %0b, expected %0b (char 0x%02h)",
                                         rsp_last, want.last, want.ch));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Write every register; upper data bits beyond a register's width carry junk.
   task automatic program_setup();
      logic [tes_pkg::CSR_DATA_W-1:0] junk;
      junk = tes_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= tes_pkg::CSR_STOP_COUNT;
      csr_wdata <= {junk[tes_pkg::CSR_DATA_W-1:tes_pkg::CNT_SC_W], setup_count};
      for (int i = 0; i < STOP_SLOTS; i++) begin
         @(posedge clock);
         csr_index <= tes_pkg::CSR_STOP_A + tes_pkg::CSR_IDX_W'(i);
         csr_wdata <= setup_stops[i];
      end
      @(posedge clock);
      csr_index <= tes_pkg::CSR_TAB_INTERVAL;
      csr_wdata <= {junk[tes_pkg::CSR_DATA_W-1:tes_pkg::IV_W], setup_interval};
      @(posedge clock);
      csr_we <= 1'b0;
      stop_count_cfg = setup_count;
      for (int i = 0; i < STOP_SLOTS; i++) stop_col_cfg[i] = setup_stops[i];
      interval_cfg = setup_interval;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_valid || expected_chars.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Random lines: mostly ordinary bytes and tabs, usually ended by a newline.
   task automatic queue_text(input int unsigned n_items, input int unsigned tab_pct,
                             input int unsigned max_line);
      int unsigned queued, len;
      queued = 0;
      while (queued < n_items) begin
         len = $urandom_range(max_line);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < tab_pct) pending_chars.push_back(tes_pkg::CH_TAB);
            else pending_chars.push_back(tes_pkg::CHAR_W'($urandom));
         end
         queued += len;
         if ($urandom_range(9) != 0) begin
            pending_chars.push_back(tes_pkg::CH_NL);
            queued++;
         end
      end
   endtask

   task automatic random_stops(input bit ascending, input int unsigned span);
      int unsigned acc;
      acc = 0;
      for (int i = 0; i < STOP_SLOTS; i++) begin
         if (ascending) begin
            acc += $urandom_range(1, span);
            setup_stops[i] = (acc > tes_pkg::COL_MAX) ? tes_pkg::COL_MAX
                                                      : tes_pkg::COL_W'(acc);
         end else begin
            setup_stops[i] = tes_pkg::COL_W'($urandom_range(span));
         end
      end
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      wait_drained();
   endtask

   initial begin
      stop_count_cfg = '0;
      for (int i = 0; i < STOP_SLOTS; i++) stop_col_cfg[i] = '0;
      interval_cfg = tes_pkg::TAB_INTERVAL_RESET;
      column       = '0;
      stop_idx     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: interval of four, no explicit stops
      pending_chars = '{8'h00, 8'hFF, tes_pkg::CH_TAB, tes_pkg::CH_TAB, 8'h41,
                        tes_pkg::CH_TAB, tes_pkg::CH_NL, tes_pkg::CH_TAB, 8'h55, 8'hAA,
                        tes_pkg::CH_NL};
      run_phase(0, 0);

      // too many stops, unordered list, zero interval, space cap
      setup_count    = 3'd7;
      setup_stops    = '{12'd5, 12'd3, 12'd70, 12'd71, 12'd200, 12'd0};
      setup_interval = 7'd0;
      program_setup();
      pending_chars = '{8'h78, 8'h78, 8'h78, tes_pkg::CH_TAB, tes_pkg::CH_TAB,
                        tes_pkg::CH_TAB, tes_pkg::CH_TAB, tes_pkg::CH_TAB, tes_pkg::CH_TAB,
                        tes_pkg::CH_TAB, tes_pkg::CH_NL, tes_pkg::CH_TAB};
      run_phase(0, 0);

      setup_count    = 3'd3;
      setup_stops    = '{12'd3, 12'd8, 12'd20, 12'd30, 12'd40, 12'd50};
      setup_interval = 7'd8;
      program_setup();
      queue_text(40, 30, 24);
      run_phase(0, 0);

      setup_count    = 3'd7;
      random_stops(1'b1, 12);
      setup_interval = 7'd0;
      program_setup();
      queue_text(40, 30, 30);
      run_phase(46, 0);

      setup_count    = tes_pkg::CNT_SC_W'($urandom_range(1, 6));
      random_stops(1'b0, 100);
      setup_interval = 7'd64;
      program_setup();
      queue_text(40, 25, 30);
      run_phase(0, 46);

      // far stops and widest interval; a long tab run drives the column to saturation
      setup_count    = 3'd6;
      setup_stops    = '{12'd0, 12'd10, 12'd50, 12'd4095, 12'd100, 12'd4095};
      setup_interval = 7'd127;
      program_setup();
      queue_text(25, 30, 20);
      repeat (80) pending_chars.push_back(tes_pkg::CH_TAB);
      pending_chars.push_back(8'h61);
      pending_chars.push_back(8'h62);
      pending_chars.push_back(tes_pkg::CH_TAB);
      pending_chars.push_back(tes_pkg::CH_NL);
      queue_text(20, 30, 20);
      run_phase(32, 32);

      // hold the output off while input keeps coming
      setup_count    = 3'd0;
      random_stops(1'b1, 30);
      setup_interval = 7'd1;
      program_setup();
      hold_arm = 1'b1;
      queue_text(35, 30, 20);
      run_phase(0, 0);
      hold_arm = 1'b0;

      setup_count    = tes_pkg::CNT_SC_W'($urandom_range(7));
      random_stops(1'b1, 20);
      setup_interval = tes_pkg::IV_W'($urandom_range(1, 64));
      program_setup();
      queue_text(50, 30, 40);
      run_phase(32, 32);

      repeat (100) @(negedge clock);
      if (expected_chars.size() != 0)
         report_error($sformatf("%0d expected output chars never arrived",
                                expected_chars.size()));
      if (mismatch_count == 0) begin
         $display("tab_expander_stop_list_tb OK");
      end else begin
         $display("tab_expander_stop_list_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("timeout");
      $display("tab_expander_stop_list_tb NOT OK");
      $finish;
   end

endmodule
